// ===== rtl/ptts_pkg.sv =====
// shared types and constants for the periodic task tick scheduler
package ptts_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int FIRED_W         = $clog2(MAX_RESULTS + 1);
  localparam int DIV_STEPS       = 32;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] FN_REG   = 2'd0;
  localparam logic [1:0] FN_UNREG = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_VALUE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_SPACE  = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       clr_idx;
    logic       inc_idx;
    logic       inc_same;
    logic       div_start;
    logic       div_sel;
    logic       latch_off;
    logic       write_entry;
    logic       shift_entry;
    logic       dec_count;
    logic       tick_step;
    logic       fire;
    logic       push_resp;
    logic [1:0] resp_status;
    logic       push_final;
    logic       inc_iter;
  } ptts_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       hook_zero;
    logic       per_zero;
    logic       full;
    logic       at_end;
    logic       per_match;
    logic       id_match;
    logic       due;
    logic       pend_valid;
    logic       push_ok;
    logic       div_done;
  } ptts_stat_t;

endpackage

// ===== rtl/ptts_mod.sv =====
// serial restoring remainder unit, one quotient bit per cycle
module ptts_mod
  import ptts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          dvd;
  logic [15:0]          dsr;
  logic [16:0]          trial;
  logic [16:0]          diff;
  logic                 ge;

  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= ge ? diff[15:0] : trial[15:0];
    end
  end

endmodule

// ===== rtl/ptts_dpath.sv =====
// task table, counters, residue tracking and output register
module ptts_dpath
  import ptts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ptts_cmd_t   cmd,
  output ptts_stat_t stat,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [7:0]  tab_hook [TABLE_DEPTH];
  logic [15:0] tab_ctx  [TABLE_DEPTH];
  logic [15:0] tab_per  [TABLE_DEPTH];
  logic [15:0] tab_off  [TABLE_DEPTH];
  logic [15:0] tab_res  [TABLE_DEPTH];

  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      same;
  logic [31:0]        iteration;
  logic [FIRED_W-1:0] nfired;

  logic [1:0]  in_func;
  logic [7:0]  in_hook;
  logic [15:0] in_ctx;
  logic [15:0] in_per;
  logic [15:0] off_q;

  logic        pend_valid;
  logic [7:0]  pend_hook;
  logic [15:0] pend_ctx;

  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_fired;
  logic [7:0]  out_hook;
  logic [15:0] out_ctx;
  logic [31:0] out_tick;
  logic        out_last;

  logic [AW-1:0] ra;
  logic [AW-1:0] wa_cnt;
  logic [AW-1:0] wa_prev;
  logic [31:0]   div_dividend;
  logic          div_done;
  logic [15:0]   div_rem;
  logic [15:0]   res_cur;
  logic [15:0]   res_inc;
  logic [15:0]   res_next;
  logic          sum_wraps;
  logic          push;
  logic          push_ok;

  assign ra      = idx[AW-1:0];
  assign wa_cnt  = count[AW-1:0];
  assign wa_prev = AW'(idx - 1'b1);

  assign div_dividend = cmd.div_sel ? (iteration + {16'b0, div_rem}) : {{(32-CW){1'b0}}, same};

  ptts_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (in_per),
    .done     (div_done),
    .rem      (div_rem)
  );

  // residue follows (iteration + offset) mod 2^32 mod period
  assign res_cur   = tab_res[ra];
  assign res_inc   = res_cur + 16'd1;
  assign sum_wraps = (iteration + {16'b0, tab_off[ra]}) == 32'hFFFF_FFFF;
  assign res_next  = (sum_wraps || res_inc == tab_per[ra]) ? 16'd0 : res_inc;

  assign push_ok = !out_valid || m_tready;
  assign push    = cmd.push_resp || cmd.push_final || (cmd.fire && pend_valid);

  assign stat.func       = in_func;
  assign stat.hook_zero  = in_hook == 8'd0;
  assign stat.per_zero   = in_per == 16'd0;
  assign stat.full       = count == CW'(TABLE_DEPTH);
  assign stat.at_end     = idx == count;
  assign stat.per_match  = tab_per[ra] == in_per;
  assign stat.id_match   = tab_hook[ra] == in_hook && tab_ctx[ra] == in_ctx;
  assign stat.due        = res_cur == 16'd0 && nfired < FIRED_W'(MAX_RESULTS);
  assign stat.pend_valid = pend_valid;
  assign stat.push_ok    = push_ok;
  assign stat.div_done   = div_done;

  // table storage
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      tab_hook[wa_cnt] <= in_hook;
      tab_ctx[wa_cnt]  <= in_ctx;
      tab_per[wa_cnt]  <= in_per;
      tab_off[wa_cnt]  <= off_q;
      tab_res[wa_cnt]  <= div_rem;
    end else if (cmd.shift_entry) begin
      tab_hook[wa_prev] <= tab_hook[ra];
      tab_ctx[wa_prev]  <= tab_ctx[ra];
      tab_per[wa_prev]  <= tab_per[ra];
      tab_off[wa_prev]  <= tab_off[ra];
      tab_res[wa_prev]  <= tab_res[ra];
    end else if (cmd.tick_step) begin
      tab_res[ra] <= res_next;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      iteration  <= '0;
      idx        <= '0;
      same       <= '0;
      nfired     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr_idx) begin
        idx        <= '0;
        same       <= '0;
        nfired     <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.inc_idx) begin
          idx <= idx + 1'b1;
        end
        if (cmd.inc_same) begin
          same <= same + 1'b1;
        end
        if (cmd.fire) begin
          nfired     <= nfired + 1'b1;
          pend_valid <= 1'b1;
        end else if (cmd.push_final) begin
          pend_valid <= 1'b0;
        end
      end
      if (cmd.write_entry) begin
        count <= count + 1'b1;
      end else if (cmd.dec_count) begin
        count <= count - 1'b1;
      end
      if (cmd.inc_iter) begin
        iteration <= iteration + 32'd1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_func <= s_tuser;
      in_hook <= s_tdata[7:0];
      in_ctx  <= s_tdata[23:8];
      in_per  <= s_tdata[39:24];
    end
    if (cmd.latch_off) begin
      off_q <= div_rem;
    end
    if (cmd.fire) begin
      pend_hook <= tab_hook[ra];
      pend_ctx  <= tab_ctx[ra];
    end
    if (cmd.push_resp) begin
      out_status <= cmd.resp_status;
      out_fired  <= 1'b0;
      out_hook   <= '0;
      out_ctx    <= '0;
      out_tick   <= '0;
      out_last   <= 1'b1;
    end else if (cmd.push_final || (cmd.fire && pend_valid)) begin
      out_status <= ST_OK;
      out_fired  <= pend_valid;
      out_hook   <= pend_valid ? pend_hook : 8'd0;
      out_ctx    <= pend_valid ? pend_ctx : 16'd0;
      out_tick   <= iteration;
      out_last   <= cmd.push_final;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_tick, out_ctx, out_hook};
  assign m_tuser  = {out_fired, out_status};
  assign m_tlast  = out_last;

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    push |-> push_ok)
    else $error("result beat overwritten before it was taken");

  a_fire_limit : assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> nfired < FIRED_W'(MAX_RESULTS))
    else $error("more due tasks reported than the result limit");

endmodule

// ===== rtl/ptts_ctrl.sv =====
// operation sequencer for the scheduler
module ptts_ctrl
  import ptts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ptts_stat_t stat,
  output ptts_cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE, DECODE, REG_SCAN, REG_DIV1, REG_DIV2,
    UNREG_SCAN, UNREG_SHIFT, TICK_WALK, TICK_END, RESP
  } state_t;

  state_t     state, state_next;
  logic [1:0] resp, resp_next;

  assign s_tready = state == IDLE;

  always_comb begin
    cmd             = '0;
    cmd.resp_status = resp;
    state_next      = state;
    resp_next       = resp;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = DECODE;
        end
      end
      DECODE: begin
        cmd.clr_idx = 1'b1;
        unique case (stat.func)
          FN_REG: begin
            if (stat.hook_zero || stat.per_zero) begin
              resp_next  = ST_BAD_VALUE;
              state_next = RESP;
            end else if (stat.full) begin
              resp_next  = ST_NO_SPACE;
              state_next = RESP;
            end else begin
              state_next = REG_SCAN;
            end
          end
          FN_UNREG: state_next = UNREG_SCAN;
          FN_TICK:  state_next = TICK_WALK;
          default: begin
            resp_next  = ST_BAD_VALUE;
            state_next = RESP;
          end
        endcase
      end
      REG_SCAN: begin
        if (stat.at_end) begin
          cmd.div_start = 1'b1;
          state_next    = REG_DIV1;
        end else begin
          cmd.inc_idx  = 1'b1;
          cmd.inc_same = stat.per_match;
        end
      end
      REG_DIV1: begin
        if (stat.div_done) begin
          cmd.latch_off = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = REG_DIV2;
        end
      end
      REG_DIV2: begin
        if (stat.div_done) begin
          cmd.write_entry = 1'b1;
          resp_next       = ST_OK;
          state_next      = RESP;
        end
      end
      UNREG_SCAN: begin
        if (stat.at_end) begin
          resp_next  = ST_NOT_FOUND;
          state_next = RESP;
        end else begin
          cmd.inc_idx = 1'b1;
          if (stat.id_match) begin
            state_next = UNREG_SHIFT;
          end
        end
      end
      UNREG_SHIFT: begin
        if (stat.at_end) begin
          cmd.dec_count = 1'b1;
          resp_next     = ST_OK;
          state_next    = RESP;
        end else begin
          cmd.shift_entry = 1'b1;
          cmd.inc_idx     = 1'b1;
        end
      end
      TICK_WALK: begin
        if (stat.at_end) begin
          state_next = TICK_END;
        end else if (!(stat.due && stat.pend_valid && !stat.push_ok)) begin
          cmd.tick_step = 1'b1;
          cmd.inc_idx   = 1'b1;
          cmd.fire      = stat.due;
        end
      end
      TICK_END: begin
        if (stat.push_ok) begin
          cmd.push_final = 1'b1;
          cmd.inc_iter   = 1'b1;
          state_next     = IDLE;
        end
      end
      RESP: begin
        if (stat.push_ok) begin
          cmd.push_resp = 1'b1;
          state_next    = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      resp  <= ST_OK;
    end else begin
      state <= state_next;
      resp  <= resp_next;
    end
  end

endmodule

// ===== rtl/periodic_task_tick_scheduler.sv =====
// top level of the periodic task tick scheduler
// Keeps an ordered table of up to TABLE_DEPTH periodic tasks and takes one
// command beat at a time: register (func 0), unregister (func 1) or tick
// (func 2). Register and unregister answer with one beat carrying a status;
// a tick answers with one beat per due task in registration order, at most
// MAX_RESULTS of them, tlast on the final one, or a single beat with fired
// clear when nothing is due. Each entry keeps a running residue of
// (iteration + offset) mod period, so a tick needs no division: it walks the
// table one entry per cycle, except that it stalls while a due task waits
// on the output side. Register walks the table to count equal periods and
// then runs two 32-step serial remainders for offset and starting residue.
// Unregister searches the table and compacts it. A new command beat is
// taken only once the previous command has finished; the last result beat
// may still sit in the output register while the next command is accepted.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // hook_id[7:0], context_tag[23:8], period[39:24]
  input  logic [1:0]  s_tuser,   // func[1:0]
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // fire_hook[7:0], fire_context[23:8], tick_number[55:24]
  output logic [2:0]  m_tuser,   // status[1:0], fired[2]
  output logic        m_tlast    // last beat caused by a command
);

  ptts_cmd_t  cmd;
  ptts_stat_t stat;

  // sequencer
  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, residues, remainder unit and output beat register
  ptts_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
